// ===== sv/nss_pkg.sv =====
// nss_pkg: shared constants for the nearest sorted search block
// table depth, field widths and item action codes; no dependencies
`timescale 1ns / 1ps

package nss_pkg;

	// table storage
	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	// counters must hold the doubled gallop probe, which reaches the depth itself
	localparam int CNT_W       = ADDR_W + 1;

	// fixed field widths of the ports
	localparam int VAL_W = 32;
	localparam int IDX_W = 10;
	localparam int LEN_W = 11;

	// differences are 33 bits; the compare of two differences needs one more
	localparam int DIFF_W = VAL_W + 1;
	localparam int SUB_W  = VAL_W + 2;

	// action codes of an input word
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

endpackage

// ===== sv/nss_ram.sv =====
// nss_ram: generic single write port, single read port memory
// registered read data; no dependencies
`timescale 1ns / 1ps

module nss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/nearest_sorted_search.sv =====
// nearest_sorted_search: nearest-value lookup in an ascending table
// depends on nss_pkg and nss_ram
//
//  channel  signals                                     direction
//  in       in_valid, in_stall, action, entry_index,    word in
//           key_value
//  out      out_valid, out_stall, nearest_index         word out
//  cfg      cfg_wr_en, cfg_wr_data (table_length)       write only
//
// a write word goes straight into the table; a query holds in_stall while it runs gallop
// compares, then binary compares, then reads the two neighbours of the lower bound unless
// it is the first entry or past the end, with a read and a subtract per probe. reset clears
// the sequencer and output valid and sets table_length to 1
// a result waits in the output register while the next word goes in, and a later
// result keeps in_stall high until that register frees
`timescale 1ns / 1ps

module nearest_sorted_search
	import nss_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_wr_en,
	input  logic [LEN_W-1:0]        cfg_wr_data,
	// input words
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    action,
	input  logic [IDX_W-1:0]        entry_index,
	input  logic signed [VAL_W-1:0] key_value,
	// results
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [IDX_W-1:0]        nearest_index
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_GAL_RD,
		S_GAL_CMP,
		S_BRACKET,
		S_BIN_RD,
		S_BIN_CMP,
		S_FINAL,
		S_RIGHT,
		S_LEFT,
		S_PICK,
		S_DONE
	} state_t;

	state_t                    state_q;
	logic [LEN_W-1:0]          len_q;
	logic [VAL_W-1:0]          key_q;
	logic [CNT_W-1:0]          n_q;
	logic [CNT_W-1:0]          lo_q;
	logic [CNT_W-1:0]          hi_q;
	logic [CNT_W-1:0]          lb_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          probe_q;
	logic [DIFF_W-1:0]         dr_q;
	logic [DIFF_W-1:0]         dl_q;
	logic [ADDR_W-1:0]         res_q;
	logic                      out_valid_q;
	logic [IDX_W-1:0]          nearest_index_q;

	logic                      in_acc;
	logic                      out_free;
	logic [CNT_W-1:0]          n_d;
	logic [CNT_W-1:0]          hi_fix;
	logic [CNT_W-1:0]          lo_fix;
	logic [CNT_W-1:0]          step;
	logic [CNT_W-1:0]          probe_d;

	logic                      ram_wr_en;
	logic [ADDR_W-1:0]         ram_wr_addr;
	logic                      ram_rd_en;
	logic [ADDR_W-1:0]         ram_rd_addr;
	logic [VAL_W-1:0]          ram_rd_data;

	logic [SUB_W-1:0]          sub_a;
	logic [SUB_W-1:0]          sub_b;
	logic [SUB_W-1:0]          sub_diff;
	logic                      sub_neg;

	assign in_stall      = (state_q != S_IDLE);
	assign in_acc        = in_valid && !in_stall;
	assign out_valid     = out_valid_q;
	assign nearest_index = nearest_index_q;
	assign out_free      = !out_valid_q || !out_stall;

	// length in use: zero acts as one, beyond the depth acts as the depth
	always_comb begin
		if (len_q == '0) begin
			n_d = CNT_W'(1);
		end else if (32'(len_q) > 32'(TABLE_DEPTH)) begin
			n_d = CNT_W'(TABLE_DEPTH);
		end else begin
			n_d = CNT_W'(len_q);
		end
	end

	// gallop bracket clipped to the length in use
	assign hi_fix  = (hi_q > n_q) ? n_q : hi_q;
	assign lo_fix  = (lo_q > n_q) ? n_q : lo_q;
	assign step    = cnt_q >> 1;
	assign probe_d = lb_q + step;

	// table memory: writes from idle words, reads from the sequencer
	assign ram_wr_en   = in_acc && (action == ACT_WRITE)
		&& (32'(entry_index) < 32'(TABLE_DEPTH));
	assign ram_wr_addr = ADDR_W'(entry_index);

	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = hi_q[ADDR_W-1:0];
		unique case (state_q)
			S_GAL_RD: begin
				ram_rd_en   = (hi_q < n_q);
				ram_rd_addr = hi_q[ADDR_W-1:0];
			end
			S_BIN_RD: begin
				ram_rd_en   = (cnt_q != '0);
				ram_rd_addr = probe_d[ADDR_W-1:0];
			end
			S_FINAL: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = lb_q[ADDR_W-1:0];
			end
			S_RIGHT: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = ADDR_W'(lb_q - CNT_W'(1));
			end
			default: begin
				ram_rd_en   = 1'b0;
				ram_rd_addr = hi_q[ADDR_W-1:0];
			end
		endcase
	end

	nss_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (key_value),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// shared subtractor: entry minus key, key minus entry, dr minus dl
	always_comb begin
		unique case (state_q)
			S_LEFT: begin
				sub_a = {{2{key_q[VAL_W-1]}}, key_q};
				sub_b = {{2{ram_rd_data[VAL_W-1]}}, ram_rd_data};
			end
			S_PICK: begin
				sub_a = {dr_q[DIFF_W-1], dr_q};
				sub_b = {dl_q[DIFF_W-1], dl_q};
			end
			default: begin
				sub_a = {{2{ram_rd_data[VAL_W-1]}}, ram_rd_data};
				sub_b = {{2{key_q[VAL_W-1]}}, key_q};
			end
		endcase
	end

	assign sub_diff = sub_a - sub_b;
	assign sub_neg  = sub_diff[SUB_W-1];

	// sequencer, configuration register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= LEN_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				len_q <= cfg_wr_data;
			end
			// a taken result clears valid unless a new one loads this cycle
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (action == ACT_QUERY)) begin
						key_q   <= key_value;
						n_q     <= n_d;
						lo_q    <= '0;
						hi_q    <= CNT_W'(1);
						state_q <= S_GAL_RD;
					end
				end
				S_GAL_RD: begin
					state_q <= (hi_q < n_q) ? S_GAL_CMP : S_BRACKET;
				end
				S_GAL_CMP: begin
					// entry below the key: move the bracket up and double
					if (sub_neg) begin
						lo_q    <= hi_q;
						hi_q    <= hi_q << 1;
						state_q <= S_GAL_RD;
					end else begin
						state_q <= S_BRACKET;
					end
				end
				S_BRACKET: begin
					lb_q    <= lo_fix;
					cnt_q   <= hi_fix - lo_fix;
					state_q <= S_BIN_RD;
				end
				S_BIN_RD: begin
					probe_q <= probe_d;
					state_q <= (cnt_q != '0) ? S_BIN_CMP : S_FINAL;
				end
				S_BIN_CMP: begin
					if (sub_neg) begin
						lb_q  <= probe_q + CNT_W'(1);
						cnt_q <= cnt_q - step - CNT_W'(1);
					end else begin
						cnt_q <= step;
					end
					state_q <= S_BIN_RD;
				end
				S_FINAL: begin
					// lower bound at the first entry or past the end
					if (lb_q == '0) begin
						res_q   <= '0;
						state_q <= S_DONE;
					end else if (lb_q >= n_q) begin
						res_q   <= ADDR_W'(n_q - CNT_W'(1));
						state_q <= S_DONE;
					end else begin
						state_q <= S_RIGHT;
					end
				end
				S_RIGHT: begin
					dr_q    <= sub_diff[DIFF_W-1:0];
					state_q <= S_LEFT;
				end
				S_LEFT: begin
					dl_q    <= sub_diff[DIFF_W-1:0];
					state_q <= S_PICK;
				end
				S_PICK: begin
					// exact hit or strictly nearer right side wins, tie goes left
					if ((dr_q == '0) || sub_neg) begin
						res_q <= lb_q[ADDR_W-1:0];
					end else begin
						res_q <= ADDR_W'(lb_q - CNT_W'(1));
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q     <= 1'b1;
						nearest_index_q <= IDX_W'(res_q);
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
